// ----- rtl/core/chru_pkg.sv -----
// ----------------------------------------------------------------------------
// chru_pkg
// shared types and constants of the hit record unpacker
// ----------------------------------------------------------------------------
package chru_pkg;

    // depth of the channel tag store, one entry per channel of a segment
    localparam int MAX_CHANNELS = 4096;
    localparam int TAG_ADDR_W   = $clog2(MAX_CHANNELS);

    // stored tag: bits 12..5 (chip) and bits 3..0 (channel)
    localparam int CHIP_W  = 8;
    localparam int CHAN_W  = 4;
    localparam int TAG_W   = CHIP_W + CHAN_W;

    localparam int WORD_W  = 16;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 12;
    localparam int SKIP_W  = COUNT_W + 1;

    localparam logic [VALUE_W-1:0] COUNT_LIMIT = 32'd4095;

    // result kinds
    localparam logic KIND_HIT   = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    // parse phase, one-hot
    typedef enum logic [5:0] {
        PH_COUNT  = 6'b000001,
        PH_TAGS   = 6'b000010,
        PH_COUNT2 = 6'b000100,
        PH_TIME   = 6'b001000,
        PH_ENERGY = 6'b010000,
        PH_SKIP   = 6'b100000
    } phase_t;

endpackage

// ----- rtl/core/chip_hit_record_unpacker.sv -----
// ----------------------------------------------------------------------------
// chip_hit_record_unpacker
// unpacks chip readout segments of 16-bit words into hit records
// ----------------------------------------------------------------------------
//
//  channel  | signals                                    | direction
//  ---------+--------------------------------------------+----------
//  word     | word_valid, word_ready, data_word,         | in
//           | end_of_event                               |
//  result   | result_valid, result_ready, result_kind,   | out
//           | chip_number, channel_number, time_value,   |
//           | energy_value, error_count                  |
//
//  one word per cycle while no result is stalled; a result appears the cycle
//  after the word that completes it
//  the channel tags live in a 4096-entry ram with one port; its address is
//  the pair index, so the tag of the next hit is already read out when its
//  energy word arrives
//  reset clears all control state; the tag ram is not cleared, every tag
//  read is written earlier in the same segment
//  a stalled result holds word_ready low; a new word is taken in the same
//  cycle the waiting result leaves
// ----------------------------------------------------------------------------
module chip_hit_record_unpacker
    import chru_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 word_valid,
    output logic                 word_ready,
    input  logic [WORD_W-1:0]    data_word,
    input  logic                 end_of_event,

    output logic                 result_valid,
    input  logic                 result_ready,
    output logic                 result_kind,
    output logic [CHIP_W-1:0]    chip_number,
    output logic [CHAN_W-1:0]    channel_number,
    output logic [VALUE_W-1:0]   time_value,
    output logic [VALUE_W-1:0]   energy_value,
    output logic [COUNT_W-1:0]   error_count
);

    // parse state
    phase_t               phase_reg,        phase_next;
    logic                 half_pending_reg, half_pending_next;
    logic [WORD_W-1:0]    low_half_reg,     low_half_next;
    logic [COUNT_W-1:0]   hit_count_reg,    hit_count_next;
    logic [COUNT_W-1:0]   pair_index_reg,   pair_index_next;
    logic [VALUE_W-1:0]   held_time_reg,    held_time_next;
    logic [SKIP_W-1:0]    skip_reg,         skip_next;

    // result slot
    logic                 result_valid_reg;
    logic                 kind_reg;
    logic [CHIP_W-1:0]    chip_reg;
    logic [CHAN_W-1:0]    chan_reg;
    logic [VALUE_W-1:0]   time_reg;
    logic [VALUE_W-1:0]   energy_reg;
    logic [COUNT_W-1:0]   err_reg;

    logic                 accept;
    logic [VALUE_W-1:0]   value;
    logic [COUNT_W-1:0]   pair_inc;
    logic [SKIP_W-1:0]    skip_dec;
    logic                 tag_wr_en;
    logic [TAG_W-1:0]     tag_wr_data;
    logic [TAG_W-1:0]     tag_rd_data;
    logic                 load_hit;
    logic                 load_err;

    // tag store; read and write share the pair index as address.
    // in the energy phase the index has been stable for at least two
    // accepted words, so the registered read is always current
    chru_ram #(
        .WIDTH (TAG_W),
        .DEPTH (MAX_CHANNELS)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (tag_wr_en),
        .addr    (pair_index_reg[TAG_ADDR_W-1:0]),
        .wr_data (tag_wr_data),
        .rd_data (tag_rd_data)
    );

    // a word is taken whenever the result slot is free or frees now
    assign word_ready = !result_valid_reg || result_ready;
    assign accept     = word_valid && word_ready;

    // high half arrives second
    assign value       = {data_word, low_half_reg};
    assign pair_inc    = pair_index_reg + COUNT_W'(1);
    assign skip_dec    = (skip_reg != '0) ? skip_reg - SKIP_W'(1) : skip_reg;
    assign tag_wr_data = {value[12:5], value[3:0]};

    always_comb
    begin
        phase_next        = phase_reg;
        half_pending_next = half_pending_reg;
        low_half_next     = low_half_reg;
        hit_count_next    = hit_count_reg;
        pair_index_next   = pair_index_reg;
        held_time_next    = held_time_reg;
        skip_next         = skip_reg;
        tag_wr_en         = 1'b0;
        load_hit          = 1'b0;
        load_err          = 1'b0;

        if (accept)
        begin
            if (phase_reg == PH_SKIP)
            begin
                // skipped words are counted singly, no half pairing
                skip_next = skip_dec;
                if (skip_dec == '0)
                begin
                    phase_next = PH_COUNT;
                end
            end
            else if (!half_pending_reg)
            begin
                low_half_next     = data_word;
                half_pending_next = 1'b1;
            end
            else
            begin
                half_pending_next = 1'b0;
                unique case (phase_reg)
                    PH_TAGS:
                    begin
                        tag_wr_en       = 1'b1;
                        pair_index_next = pair_inc;
                        if (pair_inc == hit_count_reg)
                        begin
                            phase_next = PH_COUNT2;
                        end
                    end
                    PH_COUNT2:
                    begin
                        // second count is dropped
                        pair_index_next = '0;
                        phase_next      = (hit_count_reg != '0) ? PH_TIME : PH_COUNT;
                    end
                    PH_TIME:
                    begin
                        held_time_next = value;
                        phase_next     = PH_ENERGY;
                    end
                    PH_ENERGY:
                    begin
                        load_hit        = 1'b1;
                        pair_index_next = pair_inc;
                        phase_next      = (pair_inc == hit_count_reg) ? PH_COUNT : PH_TIME;
                    end
                    default:
                    begin
                        // channel count
                        if (value > COUNT_LIMIT)
                        begin
                            load_err   = 1'b1;
                            skip_next  = {value[COUNT_W-1:0], 1'b1};
                            phase_next = PH_SKIP;
                        end
                        else
                        begin
                            hit_count_next  = value[COUNT_W-1:0];
                            pair_index_next = '0;
                            phase_next      = (value != '0) ? PH_TAGS : PH_COUNT2;
                        end
                    end
                endcase
            end

            // end of event abandons the segment after the word is used
            if (end_of_event)
            begin
                phase_next        = PH_COUNT;
                half_pending_next = 1'b0;
                low_half_next     = '0;
                skip_next         = '0;
                hit_count_next    = '0;
                pair_index_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_COUNT;
            half_pending_reg <= 1'b0;
            low_half_reg     <= '0;
            hit_count_reg    <= '0;
            pair_index_reg   <= '0;
            held_time_reg    <= '0;
            skip_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            half_pending_reg <= half_pending_next;
            low_half_reg     <= low_half_next;
            hit_count_reg    <= hit_count_next;
            pair_index_reg   <= pair_index_next;
            held_time_reg    <= held_time_next;
            skip_reg         <= skip_next;
            if (load_hit || load_err)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded only when a result is made
    always_ff @(posedge clk)
    begin
        if (load_hit)
        begin
            kind_reg   <= KIND_HIT;
            chip_reg   <= tag_rd_data[TAG_W-1:CHAN_W];
            chan_reg   <= tag_rd_data[CHAN_W-1:0];
            time_reg   <= held_time_reg;
            energy_reg <= value;
            err_reg    <= '0;
        end
        else if (load_err)
        begin
            kind_reg   <= KIND_ERROR;
            chip_reg   <= '0;
            chan_reg   <= '0;
            time_reg   <= '0;
            energy_reg <= '0;
            err_reg    <= value[COUNT_W-1:0];
        end
    end

    assign result_valid   = result_valid_reg;
    assign result_kind    = kind_reg;
    assign chip_number    = chip_reg;
    assign channel_number = chan_reg;
    assign time_value     = time_reg;
    assign energy_value   = energy_reg;
    assign error_count    = err_reg;

    // end of event always leaves the parser waiting for a fresh count
    a_eoe_abandons: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_event |=> phase_reg == PH_COUNT && !half_pending_reg)
        else $error("end of event did not abandon the segment");

    // results come only from a completed 32-bit value
    a_result_on_high_half: assert property (@(posedge clk) disable iff (!rst_n)
        (load_hit || load_err) |-> half_pending_reg && accept)
        else $error("result made without a completed value");

    // while reading pairs the index stays below the channel count
    a_pair_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TIME || phase_reg == PH_ENERGY) |->
            pair_index_reg < hit_count_reg)
        else $error("pair index beyond channel count");

    // no half is held during an error skip
    a_skip_no_half: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SKIP |-> !half_pending_reg)
        else $error("half pending during skip");

endmodule

// ----- rtl/core/chru_ram.sv -----
// ----------------------------------------------------------------------------
// chru_ram
// generic single-port ram, synchronous write, registered read
// ----------------------------------------------------------------------------
module chru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wr_data,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        rd_data_reg <= mem[addr];
    end

    assign rd_data = rd_data_reg;

endmodule
